// File: hdl/jls_pkg.sv
// ----------------------------------------------------------------------------
// jls_pkg: shared types, codes and helpers for the Jacobi linear solver
// Q16.32 fixed-point helpers, status and action codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package jls_pkg;

	localparam int VAL_W = 48;
	localparam int DIV_STEPS = 80;
	localparam int DIV_CNT_W = 7;

	typedef logic [VAL_W-1:0] val_t;

	localparam logic [VAL_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] NEG_MAX = 48'h8000_0000_0000;
	localparam logic [63:0] MAG_LIMIT = 64'h0000_8000_0000_0000;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_START = 1'b1;

	localparam logic [1:0] ST_CONV = 2'd0;
	localparam logic [1:0] ST_LIMIT = 2'd1;
	localparam logic [1:0] ST_DIAG = 2'd2;

	localparam logic [1:0] REG_ORDER = 2'd0;
	localparam logic [1:0] REG_MAX_ITER = 2'd1;
	localparam logic [1:0] REG_TOL = 2'd2;

	// magnitude of a signed 48-bit value; -2^47 gives 2^47
	function automatic val_t mag48(input val_t v);
		mag48 = v[VAL_W-1] ? (~v + 48'd1) : v;
	endfunction

	// clamp a 49-bit signed value to 48 bits
	function automatic val_t sat49(input logic [VAL_W:0] v);
		if (v[VAL_W] != v[VAL_W-1]) begin
			sat49 = v[VAL_W] ? NEG_MAX : POS_MAX;
		end else begin
			sat49 = v[VAL_W-1:0];
		end
	endfunction

	// apply a sign to a magnitude, saturating to 48 bits
	function automatic val_t sat_mag(input logic [63:0] m, input logic neg);
		if (m >= MAG_LIMIT) begin
			sat_mag = neg ? NEG_MAX : POS_MAX;
		end else begin
			sat_mag = neg ? (~m[VAL_W-1:0] + 48'd1) : m[VAL_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: hdl/jls_mul.sv
// ----------------------------------------------------------------------------
// jls_mul: shared 48x48 unsigned multiplier
// Four 24x24 partial products accumulated into a 96-bit product, one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module jls_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire jls_pkg::val_t      a,
	input  wire jls_pkg::val_t      b,
	output logic                    done,
	output logic [95:0]             prod
);
	import jls_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [1:0]  step_q;
	val_t        a_q;
	val_t        b_q;
	logic [95:0] prod_q;
	logic [23:0] ah;
	logic [23:0] bh;
	logic [47:0] pp;
	logic [95:0] pp_sh;

	always_comb begin
		ah = step_q[0] ? a_q[47:24] : a_q[23:0];
		bh = step_q[1] ? b_q[47:24] : b_q[23:0];
		pp = ah * bh;
		case (step_q)
			2'd0: pp_sh = {48'd0, pp};
			2'd3: pp_sh = {pp, 48'd0};
			default: pp_sh = {24'd0, pp, 24'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= prod_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule
`default_nettype wire

// File: hdl/jls_div.sv
// ----------------------------------------------------------------------------
// jls_div: restoring divider for Q16.32 quotients
// Computes (num * 2^32) / den on magnitudes, one quotient bit a cycle,
// flagging a quotient that exceeds 2^47.
// ----------------------------------------------------------------------------
`default_nettype none
module jls_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire jls_pkg::val_t      num,
	input  wire jls_pkg::val_t      den,
	output logic                    done,
	output logic [48:0]             quo
);
	import jls_pkg::*;

	localparam logic [48:0] Q_LIMIT = 49'h0_8000_0000_0000;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	val_t                 num_q;
	val_t                 den_q;
	val_t                 rem_q;
	logic [48:0]          q_q;
	logic                 big_q;
	logic [48:0]          rs;
	logic [48:0]          rd;
	logic                 ge;
	logic [48:0]          qn;

	always_comb begin
		rs = {rem_q, num_q[VAL_W-1]};
		ge = (rs >= {1'b0, den_q});
		rd = ge ? (rs - {1'b0, den_q}) : rs;
		qn = {q_q[47:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= rd[VAL_W-1:0];
			num_q <= {num_q[VAL_W-2:0], 1'b0};
			// freeze the quotient once it is out of range
			if (!big_q) begin
				q_q <= qn;
				if (qn > Q_LIMIT) begin
					big_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = big_q ? (Q_LIMIT + 49'd1) : q_q;

endmodule
`default_nettype wire

// File: hdl/jacobi_linear_solver.sv
// ----------------------------------------------------------------------------
// jacobi_linear_solver: fixed-point Jacobi iteration solver
// Loads an augmented matrix entry by entry; on start checks each diagonal
// magnitude is nonzero and no smaller than any in its row, iterates from zero
// to a relative change within tolerance and emits the solution or one status item.
//
// Channel   Dir  Transfer                       Payload
// s_*       in   load entry or start            tuser action, tdata row/col/value
// m_*       out  solution component or status   tuser status, tdata idx/value/iters
// cfg_*     in   register write, no wait        order, max_iterations, tolerance
//
// A start runs the diagonal check, then the iterations, each built on the
// 80-step divider and the four-pass shared multiplier; then the solution
// components are output in turn.
// s_tready is high only while idle; m_tvalid holds its item until m_tready.
// Reset clears control and sets configuration to its defaults; the matrix store is unset.
// ----------------------------------------------------------------------------
`default_nettype none
module jacobi_linear_solver #(
	parameter int MAX_ORDER = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // row[2:0], column[6:3], entry_value[54:7]
	input  wire logic        s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // unknown_index[2:0], solution_value[50:3],
	                                    // iterations_used[60:51]
	output logic [1:0]       m_tuser,   // status
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import jls_pkg::*;

	localparam int NCOL = MAX_ORDER + 1;
	localparam int DEPTH = MAX_ORDER * NCOL;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_ORDER + 1);
	localparam int IW = $clog2(MAX_ORDER);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CK_DRD = 5'd1;
	localparam logic [4:0] S_CK_D   = 5'd2;
	localparam logic [4:0] S_CK_RD  = 5'd3;
	localparam logic [4:0] S_CK_CMP = 5'd4;
	localparam logic [4:0] S_IT_BEG = 5'd5;
	localparam logic [4:0] S_ROW    = 5'd6;
	localparam logic [4:0] S_IT_J   = 5'd7;
	localparam logic [4:0] S_IT_MUL = 5'd8;
	localparam logic [4:0] S_IT_MW  = 5'd9;
	localparam logic [4:0] S_RHS_RD = 5'd10;
	localparam logic [4:0] S_RHS    = 5'd11;
	localparam logic [4:0] S_DG_RD  = 5'd12;
	localparam logic [4:0] S_DIV    = 5'd13;
	localparam logic [4:0] S_DIV_W  = 5'd14;
	localparam logic [4:0] S_TOL    = 5'd15;
	localparam logic [4:0] S_TOL_W  = 5'd16;
	localparam logic [4:0] S_EMIT   = 5'd17;
	localparam logic [4:0] S_STAT   = 5'd18;

	// configuration
	logic [3:0]  order_q;
	logic [9:0]  max_iter_q;
	logic [31:0] tol_q;

	// control
	logic [4:0]    state_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] o_q;
	logic [10:0]   k_q;
	logic          bank_q;
	logic          first_q;
	logic          out_valid_q;

	// payload
	val_t        mem_q [DEPTH];
	val_t        mem_rd_q;
	val_t        est_q [2][MAX_ORDER];
	val_t        diag_q;
	val_t        acc_q;
	logic        neg_q;
	logic [48:0] dif_q;
	val_t        mx_q;
	logic [1:0]  stat_st_q;
	logic [9:0]  stat_its_q;
	logic [2:0]  out_idx_q;
	val_t        out_val_q;
	logic [9:0]  out_its_q;
	logic [1:0]  out_st_q;
	logic        out_last_q;

	// decoded input and internal nets
	logic [2:0]    in_row;
	logic [3:0]    in_col;
	val_t          in_val;
	logic          in_xfer;
	logic          slot;
	logic          out_load;
	logic          load_hit;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] rd_col;
	logic [CW-1:0] n_clamp;
	logic [CW-1:0] est_idx;
	logic          est_bank;
	val_t          est_rd;
	val_t          prev_val;
	val_t          rd_mag;
	logic          mul_start;
	val_t          mul_a;
	val_t          mul_b;
	logic          mul_done;
	logic [95:0]   mul_prod;
	val_t          term;
	logic          div_start;
	logic          div_done;
	logic [48:0]   div_quo;
	val_t          cur_val;
	logic [48:0]   diff;
	logic [48:0]   diff_mag;
	val_t          cur_mag;
	logic [48:0]   dif_next;
	val_t          mx_next;
	logic          i_last;
	logic          j_last;
	logic          conv;

	assign in_row = s_tdata[2:0];
	assign in_col = s_tdata[6:3];
	assign in_val = s_tdata[54:7];
	assign s_tready = (state_q == S_IDLE);
	assign in_xfer = s_tvalid && s_tready;
	assign slot = !out_valid_q || m_tready;
	assign out_load = slot && (state_q == S_EMIT || state_q == S_STAT);
	assign load_hit = in_xfer && (s_tuser == ACT_LOAD) && (int'(in_row) < MAX_ORDER)
		&& (int'(in_col) <= MAX_ORDER);
	assign wr_addr = AW'(AW'(in_row) * AW'(NCOL) + AW'(in_col));
	assign i_last = (i_q == n_q - CW'(1));
	assign j_last = (j_q == n_q - CW'(1));

	always_comb begin
		if (order_q == 4'd0) begin
			n_clamp = CW'(1);
		end else if (int'(order_q) > MAX_ORDER) begin
			n_clamp = CW'(MAX_ORDER);
		end else begin
			n_clamp = CW'(order_q);
		end
	end

	always_comb begin
		if (state_q == S_CK_DRD || state_q == S_DG_RD) begin
			rd_col = i_q;
		end else if (state_q == S_RHS_RD) begin
			rd_col = n_q;
		end else begin
			rd_col = j_q;
		end
		rd_addr = AW'(AW'(i_q) * AW'(NCOL) + AW'(rd_col));
	end

	// one read place into the estimates: previous bank at j or i, current at o
	always_comb begin
		if (state_q == S_EMIT) begin
			est_idx = o_q;
			est_bank = ~bank_q;
		end else if (state_q == S_DIV_W) begin
			est_idx = i_q;
			est_bank = bank_q;
		end else begin
			est_idx = j_q;
			est_bank = bank_q;
		end
		est_rd = est_q[est_bank][est_idx[IW-1:0]];
		prev_val = first_q ? '0 : est_rd;
	end

	assign rd_mag = mag48(mem_rd_q);
	assign mul_start = (state_q == S_IT_MUL) || (state_q == S_TOL);
	assign mul_a = (state_q == S_TOL) ? mx_q : rd_mag;
	assign mul_b = (state_q == S_TOL) ? {16'd0, tol_q} : mag48(prev_val);
	assign term = sat_mag(mul_prod[95:32] + 64'(mul_prod[31]), neg_q);
	assign div_start = (state_q == S_DIV);

	always_comb begin
		cur_val = sat_mag({15'd0, div_quo}, neg_q);
		diff = {cur_val[VAL_W-1], cur_val} - {prev_val[VAL_W-1], prev_val};
		diff_mag = diff[48] ? (~diff + 49'd1) : diff;
		cur_mag = mag48(cur_val);
		dif_next = (diff_mag > dif_q) ? diff_mag : dif_q;
		mx_next = (cur_mag > mx_q) ? cur_mag : mx_q;
		conv = ({15'd0, dif_q, 32'd0} <= mul_prod);
	end

	jls_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	jls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag48(acc_q)),
		.den    (rd_mag),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 4'd3;
			max_iter_q <= 10'd300;
			tol_q <= 32'd4295;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORDER: order_q <= cfg_data[3:0];
				REG_MAX_ITER: max_iter_q <= cfg_data[9:0];
				REG_TOL: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			o_q <= '0;
			k_q <= '0;
			bank_q <= 1'b0;
			first_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && s_tuser == ACT_START) begin
						n_q <= n_clamp;
						i_q <= '0;
						state_q <= S_CK_DRD;
					end
				end
				S_CK_DRD: state_q <= S_CK_D;
				S_CK_D: begin
					j_q <= '0;
					state_q <= (rd_mag == '0) ? S_STAT : S_CK_RD;
				end
				S_CK_RD: state_q <= S_CK_CMP;
				S_CK_CMP: begin
					if (diag_q < rd_mag) begin
						state_q <= S_STAT;
					end else if (!j_last) begin
						j_q <= j_q + CW'(1);
						state_q <= S_CK_RD;
					end else if (!i_last) begin
						i_q <= i_q + CW'(1);
						state_q <= S_CK_DRD;
					end else begin
						k_q <= 11'd1;
						bank_q <= 1'b0;
						first_q <= 1'b1;
						state_q <= S_IT_BEG;
					end
				end
				S_IT_BEG: begin
					i_q <= '0;
					state_q <= (k_q > {1'b0, max_iter_q}) ? S_STAT : S_ROW;
				end
				S_ROW: begin
					j_q <= '0;
					state_q <= S_IT_J;
				end
				S_IT_J: begin
					if (j_q == n_q) begin
						state_q <= S_RHS_RD;
					end else if (j_q == i_q) begin
						j_q <= j_q + CW'(1);
					end else begin
						state_q <= S_IT_MUL;
					end
				end
				S_IT_MUL: state_q <= S_IT_MW;
				S_IT_MW: begin
					if (mul_done) begin
						j_q <= j_q + CW'(1);
						state_q <= S_IT_J;
					end
				end
				S_RHS_RD: state_q <= S_RHS;
				S_RHS: state_q <= S_DG_RD;
				S_DG_RD: state_q <= S_DIV;
				S_DIV: state_q <= S_DIV_W;
				S_DIV_W: begin
					if (div_done) begin
						if (i_last) begin
							state_q <= S_TOL;
						end else begin
							i_q <= i_q + CW'(1);
							state_q <= S_ROW;
						end
					end
				end
				S_TOL: state_q <= S_TOL_W;
				S_TOL_W: begin
					if (mul_done) begin
						if (conv) begin
							o_q <= '0;
							state_q <= S_EMIT;
						end else begin
							bank_q <= ~bank_q;
							first_q <= 1'b0;
							k_q <= k_q + 11'd1;
							state_q <= S_IT_BEG;
						end
					end
				end
				S_EMIT: begin
					if (slot) begin
						o_q <= o_q + CW'(1);
						if (o_q == n_q - CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_STAT: begin
					if (slot) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers and stores
	always_ff @(posedge clk) begin
		if (load_hit) begin
			mem_q[wr_addr] <= in_val;
		end
		mem_rd_q <= mem_q[rd_addr];
		case (state_q)
			S_CK_D: begin
				diag_q <= rd_mag;
				if (rd_mag == '0) begin
					stat_st_q <= ST_DIAG;
					stat_its_q <= '0;
				end
			end
			S_CK_CMP: begin
				stat_st_q <= ST_DIAG;
				stat_its_q <= '0;
			end
			S_IT_BEG: begin
				dif_q <= '0;
				mx_q <= '0;
				stat_st_q <= ST_LIMIT;
				stat_its_q <= max_iter_q;
			end
			S_ROW: acc_q <= '0;
			S_IT_MUL: neg_q <= mem_rd_q[VAL_W-1] ^ prev_val[VAL_W-1];
			S_IT_MW: begin
				if (mul_done) begin
					acc_q <= sat49({acc_q[VAL_W-1], acc_q} - {term[VAL_W-1], term});
				end
			end
			S_RHS: acc_q <= sat49({acc_q[VAL_W-1], acc_q} + {mem_rd_q[VAL_W-1], mem_rd_q});
			S_DIV: neg_q <= acc_q[VAL_W-1] ^ mem_rd_q[VAL_W-1];
			S_DIV_W: begin
				if (div_done) begin
					est_q[~bank_q][i_q[IW-1:0]] <= cur_val;
					dif_q <= dif_next;
					mx_q <= mx_next;
				end
			end
			S_EMIT: begin
				if (slot) begin
					out_idx_q <= 3'(o_q);
					out_val_q <= est_rd;
					out_its_q <= k_q[9:0];
					out_st_q <= ST_CONV;
					out_last_q <= (o_q == n_q - CW'(1));
				end
			end
			S_STAT: begin
				if (slot) begin
					out_idx_q <= '0;
					out_val_q <= '0;
					out_its_q <= stat_its_q;
					out_st_q <= stat_st_q;
					out_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'd0, out_its_q, out_val_q, out_idx_q};
	assign m_tuser = out_st_q;
	assign m_tlast = out_last_q;

endmodule
`default_nettype wire

// File: hdl/jls_chk.sv
// ----------------------------------------------------------------------------
// jls_chk: port-level checks for the Jacobi linear solver
// Watches the stream ports for result framing, output hold and start behavior.
// ----------------------------------------------------------------------------
`default_nettype none
module jls_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);
	import jls_pkg::*;

	// a start transfer makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_START |=> !s_tready)
		else $error("solver still ready after a start transfer");

	// a status item is a lone item with zero index and value
	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_CONV |-> m_tlast && m_tdata[50:0] == 51'd0)
		else $error("status item malformed");

	// a failed diagonal check reports no iterations
	a_diag_its: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DIAG |-> m_tdata[60:51] == 10'd0)
		else $error("diagonal failure with nonzero iteration count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

endmodule

bind jacobi_linear_solver jls_chk u_jls_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// File: bench/jls_checker.sv
// ----------------------------------------------------------------------------
// jls_checker: result checker for the Jacobi linear solver
// Tracks the matrix and register writes, solves each started system
// independently in Q16.32 fixed point, and compares every output transfer
// field by field against the oldest predicted item.
// ----------------------------------------------------------------------------
module jls_checker
	import jls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fails,
	output int          pending
);

	localparam int N_MAX = 8;

	typedef struct {
		logic [2:0]  idx;
		logic [47:0] value;
		logic [9:0]  iters;
		logic [1:0]  status;
		logic        last;
	} sol_item_t;

	sol_item_t solution_q[$];

	longint coef[N_MAX][N_MAX+1];
	logic [3:0]  order_r;
	logic [9:0]  iter_limit;
	logic [31:0] tol_r;

	function automatic logic [63:0] abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// apply sign to a magnitude, clamping to the 48-bit range
	function automatic longint signed_clamp(logic [127:0] m, bit neg);
		if (m >= 128'h8000_0000_0000)
			return neg ? -longint'(64'h8000_0000_0000) : longint'(64'h7FFF_FFFF_FFFF);
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint clamp48(longint v);
		if (v > longint'(64'h7FFF_FFFF_FFFF)) return 64'h7FFF_FFFF_FFFF;
		if (v < -longint'(64'h8000_0000_0000)) return -longint'(64'h8000_0000_0000);
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
		p = (p + 128'h8000_0000) >> 32;
		return signed_clamp(p, (a < 0) != (b < 0));
	endfunction

	function automatic longint fx_div(longint num, longint den);
		logic [127:0] q;
		q = ({64'd0, abs64(num)} << 32) / {64'd0, abs64(den)};
		return signed_clamp(q, (num < 0) != (den < 0));
	endfunction

	function automatic bit close_enough(logic [63:0] dif, logic [63:0] mx, logic [31:0] tol);
		return ({64'd0, dif} << 32) <= ({96'd0, tol} * {64'd0, mx});
	endfunction

	function automatic sol_item_t status_item(logic [1:0] st, logic [9:0] its);
		sol_item_t s;
		s.idx = '0; s.value = '0; s.iters = its; s.status = st; s.last = 1'b1;
		return s;
	endfunction

	task automatic solve_system();
		int n, k, conv_at;
		longint prev[N_MAX], cur[N_MAX], acc;
		logic [63:0] dif, mx, dg;
		sol_item_t s;
		n = order_r == 0 ? 1 : (order_r > N_MAX ? N_MAX : order_r);
		for (int i = 0; i < n; i++) begin
			dg = abs64(coef[i][i]);
			if (dg == 0) begin
				solution_q.push_back(status_item(ST_DIAG, 10'd0));
				return;
			end
			for (int j = 0; j < n; j++)
				if (dg < abs64(coef[i][j])) begin
					solution_q.push_back(status_item(ST_DIAG, 10'd0));
					return;
				end
		end
		for (int i = 0; i < N_MAX; i++) begin
			prev[i] = 0;
			cur[i] = 0;
		end
		conv_at = 0;
		for (k = 1; k <= iter_limit; k++) begin
			dif = 0;
			mx = 0;
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					if (j != i) acc = clamp48(acc - fx_mul(coef[i][j], prev[j]));
				acc = clamp48(acc + coef[i][n]);
				cur[i] = fx_div(acc, coef[i][i]);
			end
			for (int i = 0; i < n; i++) begin
				if (abs64(cur[i] - prev[i]) > dif) dif = abs64(cur[i] - prev[i]);
				if (abs64(cur[i]) > mx) mx = abs64(cur[i]);
			end
			if (close_enough(dif, mx, tol_r)) begin
				conv_at = k;
				break;
			end
			for (int i = 0; i < n; i++) prev[i] = cur[i];
		end
		if (conv_at == 0) begin
			solution_q.push_back(status_item(ST_LIMIT, iter_limit));
			return;
		end
		for (int i = 0; i < n; i++) begin
			s.idx = i[2:0];
			s.value = cur[i][47:0];
			s.iters = conv_at[9:0];
			s.status = ST_CONV;
			s.last = (i == n - 1);
			solution_q.push_back(s);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sol_item_t e;
		if (!arst_n) begin
			order_r <= 4'd3;
			iter_limit <= 10'd300;
			tol_r <= 32'd4295;
			fails <= 0;
			pending <= 0;
			for (int i = 0; i < N_MAX; i++)
				for (int j = 0; j <= N_MAX; j++) coef[i][j] = 0;
			solution_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ORDER: order_r <= cfg_data[3:0];
					REG_MAX_ITER: iter_limit <= cfg_data[9:0];
					REG_TOL: tol_r <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_START) solve_system();
				else if (s_tdata[6:3] <= N_MAX)
					coef[s_tdata[2:0]][s_tdata[6:3]] = longint'(signed'(s_tdata[54:7]));
			end
			if (m_tvalid && m_tready) begin
				if (solution_q.size() == 0) begin
					$display("%0t: unexpected result transfer %h user %h last %b",
						$time, m_tdata, m_tuser, m_tlast);
					fails <= fails + 1;
				end else begin
					e = solution_q.pop_front();
					if (m_tdata[2:0] !== e.idx || m_tdata[50:3] !== e.value ||
					    m_tdata[60:51] !== e.iters || m_tuser !== e.status ||
					    m_tlast !== e.last) begin
						$display("%0t: mismatch expected idx %0d value %h iters %0d status %0d last %b",
							$time, e.idx, e.value, e.iters, e.status, e.last);
						$display("%0t:          actual   idx %0d value %h iters %0d status %0d last %b",
							$time, m_tdata[2:0], m_tdata[50:3], m_tdata[60:51], m_tuser,
							m_tlast);
						fails <= fails + 1;
					end
				end
			end
			pending <= solution_q.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the Jacobi linear solver
// Loads whole systems of random and corner-case matrices under several
// register settings, starts the solver, and lets the checker score results.
// ----------------------------------------------------------------------------
module tb_top;
	import jls_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fails, pending;
	int          items;
	bit          burst;
	int          ready_hold = 0;

	jacobi_linear_solver DUT (.*);
	jls_checker CHK (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("jacobi_linear_solver regression: fail");
		$finish;
	end

	// receiver side: long ready runs, short stalls and the odd long stall
	always @(negedge clk) begin
		int r;
		if (ready_hold == 0) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				m_tready <= 1'b1;
				ready_hold = $urandom_range(1, 20);
			end else if (r < 92) begin
				m_tready <= 1'b0;
				ready_hold = $urandom_range(1, 3);
			end else begin
				m_tready <= 1'b0;
				ready_hold = $urandom_range(10, 60);
			end
		end else ready_hold--;
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// caller sits just after a falling edge; returns just after one
	task automatic put(logic act, logic [2:0] row, logic [3:0] col, logic [47:0] val);
		int r, gap;
		r = $urandom_range(0, 99);
		gap = burst ? 0 : (r < 70 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(8, 30)));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {1'b0, val, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		if (act == ACT_START || col <= 4'd8) items++;
	endtask

	task automatic start_solve();
		put(ACT_START, 3'($urandom()), 4'($urandom()), rand48());
	endtask

	// drain all expected results, then let the block go fully idle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0 || !s_tready) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic program_regs(logic [3:0] ord, logic [9:0] lim, logic [31:0] tol);
		cfg_we <= 1'b1;
		cfg_index <= REG_ORDER;
		cfg_data <= 32'(ord);
		@(negedge clk);
		cfg_index <= REG_MAX_ITER;
		cfg_data <= 32'(lim);
		@(negedge clk);
		cfg_index <= REG_TOL;
		cfg_data <= tol;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// kind 0: diagonally dominant, 1: unrestricted, 2: dominant with zero rhs
	task automatic load_system(int n, int kind);
		logic [63:0] dmag, off;
		logic [47:0] v;
		for (int i = 0; i < n; i++) begin
			dmag = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom())};
			for (int j = 0; j <= n; j++) begin
				if (kind == 1) v = rand48();
				else if (j == i) v = $urandom_range(0, 1) ? dmag[47:0] : -dmag[47:0];
				else if (j == n) begin
					if (kind == 2) v = '0;
					else if ($urandom_range(0, 3) == 0) v = rand48();
					else begin
						v = {{8{1'b0}}, 8'($urandom()), 32'($urandom())};
						if ($urandom_range(0, 1) == 1) v = -v;
					end
				end else begin
					off = {16'd0, rand48()} % (dmag / (2 * n) + 1);
					v = $urandom_range(0, 1) ? off[47:0] : -off[47:0];
				end
				put(ACT_LOAD, i[2:0], j[3:0], v);
			end
		end
	endtask

	initial begin
		int ord, n, r, kind;
		logic [31:0] tol;
		logic [9:0] lim;
		items = 0;
		burst = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults after reset
		load_system(3, 0);
		start_solve();
		// order zero acts as one, zero iteration limit
		settle();
		program_regs(4'd0, 10'd0, 32'd4295);
		load_system(1, 0);
		start_solve();
		// zero diagonal
		settle();
		program_regs(4'd1, 10'd1023, 32'd0);
		put(ACT_LOAD, 3'd0, 4'd0, 48'd0);
		start_solve();
		// tiny diagonal with extreme right-hand sides saturates the quotient
		put(ACT_LOAD, 3'd0, 4'd0, 48'd1);
		put(ACT_LOAD, 3'd0, 4'd1, 48'h7FFF_FFFF_FFFF);
		start_solve();
		put(ACT_LOAD, 3'd0, 4'd1, 48'h8000_0000_0000);
		start_solve();
		// ignored columns and an unused one, extreme values
		put(ACT_LOAD, 3'd7, 4'd15, 48'hFFFF_FFFF_FFFF);
		put(ACT_LOAD, 3'd5, 4'd9, 48'h8000_0000_0000);
		put(ACT_LOAD, 3'd0, 4'd8, 48'h7FFF_FFFF_FFFF);
		// zero solution converges on the first iteration
		settle();
		program_regs(4'd2, 10'd300, 32'd4295);
		load_system(2, 2);
		start_solve();
		// order above the built maximum acts as the maximum
		settle();
		program_regs(4'd15, 10'd40, 32'hFFFF_FFFF);
		load_system(8, 0);
		start_solve();

		while (items < 300) begin
			settle();
			burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			ord = r < 5 ? 0 : (r < 10 ? $urandom_range(9, 15) :
				(r < 25 ? $urandom_range(5, 8) : $urandom_range(1, 4)));
			n = ord == 0 ? 1 : (ord > 8 ? 8 : ord);
			r = $urandom_range(0, 99);
			lim = r < 3 ? 10'd0 : (r < 15 ? 10'd1 : 10'($urandom_range(2, 50)));
			if (n <= 2 && $urandom_range(0, 4) == 0) lim = 10'd1023;
			r = $urandom_range(0, 3);
			tol = r == 0 ? 32'd0 : (r == 1 ? 32'd4295 : (r == 2 ? $urandom() : 32'hFFFF_FFFF));
			r = $urandom_range(0, 99);
			kind = r < 75 ? 0 : (r < 90 ? 1 : 2);
			// unrestricted matrices rarely converge; keep them cheap
			if (kind == 1 && lim > 10'd50) lim = 10'd50;
			program_regs(ord[3:0], lim, tol);
			load_system(n, kind);
			if ($urandom_range(0, 2) == 0)
				put(ACT_LOAD, 3'($urandom()), 4'($urandom_range(9, 15)), rand48());
			start_solve();
		end

		settle();
		if (fails == 0) $display("jacobi_linear_solver regression: pass");
		else $display("jacobi_linear_solver regression: fail");
		$finish;
	end

endmodule
